// ===== rtl/aarm_pkg.sv =====
// package: types, constants and the arctangent table for the rotation matrix core
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

	localparam int AtanEntries = 24;
	localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
	localparam logic signed [33:0] HalfPiQ29 = 34'sd843314857;
	localparam logic signed [33:0] PiQ29 = 34'sd1686629713;

	typedef logic signed [33:0] cordic_word_t;

	typedef struct packed {
		cordic_word_t x;
		cordic_word_t y;
		cordic_word_t z;
		logic flip;
	} cordic_state_t;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} axis_t;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} matrix_t;

	function automatic cordic_word_t atan_q29(input logic [4:0] idx);
		cordic_word_t v;
		case (idx)
			5'd0: v = 34'sd421657428;
			5'd1: v = 34'sd248918915;
			5'd2: v = 34'sd131521918;
			5'd3: v = 34'sd66762579;
			5'd4: v = 34'sd33510843;
			5'd5: v = 34'sd16771758;
			5'd6: v = 34'sd8387925;
			5'd7: v = 34'sd4194219;
			5'd8: v = 34'sd2097141;
			5'd9: v = 34'sd1048575;
			5'd10: v = 34'sd524288;
			5'd11: v = 34'sd262144;
			5'd12: v = 34'sd131072;
			5'd13: v = 34'sd65536;
			5'd14: v = 34'sd32768;
			5'd15: v = 34'sd16384;
			5'd16: v = 34'sd8192;
			5'd17: v = 34'sd4096;
			5'd18: v = 34'sd2048;
			5'd19: v = 34'sd1024;
			5'd20: v = 34'sd512;
			5'd21: v = 34'sd256;
			5'd22: v = 34'sd128;
			5'd23: v = 34'sd64;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/aarm_stream_if.sv =====
// valid/ready channel interface carrying one item payload
`timescale 1ns / 1ps
`default_nettype none
interface aarm_stream_if #(
	parameter int W = 64
);
	logic valid;
	logic ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/aarm_cordic_cell.sv =====
// one cordic rotation cell: a single micro-rotation with pipeline register
`timescale 1ns / 1ps
`default_nettype none
module aarm_cordic_cell
	import aarm_pkg::*;
#(
	parameter int STEP = 0
) (
	input wire clk,
	input wire en,
	input cordic_state_t st_in,
	input axis_t axis_in,
	output cordic_state_t st_s1,
	output axis_t axis_s1
);
	localparam logic [4:0] StepIdx = 5'(STEP);

	cordic_word_t dx;
	cordic_word_t dy;
	cordic_word_t at;
	cordic_state_t nxt;

	always_comb begin
		dx = st_in.x >>> STEP;
		dy = st_in.y >>> STEP;
		at = atan_q29(StepIdx);
		nxt.flip = st_in.flip;
		if (!st_in.z[33]) begin
			nxt.x = st_in.x - dy;
			nxt.y = st_in.y + dx;
			nxt.z = st_in.z - at;
		end else begin
			nxt.x = st_in.x + dy;
			nxt.y = st_in.y - dx;
			nxt.z = st_in.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt;
			axis_s1 <= axis_in;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/aarm_matrix_stage.sv =====
// matrix build: k*k products, sin/cos rounding, scaled terms and saturation
`timescale 1ns / 1ps
`default_nettype none
module aarm_matrix_stage
	import aarm_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input wire clk,
	input wire en1,
	input wire en2,
	input wire en3,
	input cordic_state_t st_in,
	input axis_t axis_in,
	output matrix_t mat_s3
);
	localparam int Sh = 30 - FRAC_BITS;
	localparam logic signed [33:0] One = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [33:0] CsRnd = (Sh > 0) ? (34'sd1 <<< (Sh - 1)) : 34'sd0;
	localparam int SW = FRAC_BITS + 3;
	localparam int SpW = SW + 17;
	localparam int OpW = SW + 34;
	localparam logic signed [SpW-1:0] SpRnd = SpW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [OpW-1:0] OpRnd = OpW'(1) <<< (2*FRAC_BITS - 1);

	// stage 1: sin, cos, k*k
	cordic_word_t xr;
	cordic_word_t ys;
	cordic_word_t sr;
	cordic_word_t cr;
	logic signed [SW-1:0] s_s1;
	logic signed [SW-1:0] omc_s1;
	logic signed [33:0] kk_s1 [9];
	logic signed [16:0] k_s1 [9];
	logic signed [16:0] kv [9];
	logic signed [33:0] kkv [9];

	always_comb begin
		xr = st_in.flip ? -st_in.x : st_in.x;
		ys = st_in.y;
		sr = (ys + CsRnd) >>> Sh;
		cr = (xr + CsRnd) >>> Sh;
		if (sr > One) sr = One;
		if (sr < -One) sr = -One;
		if (cr > One) cr = One;
		if (cr < -One) cr = -One;
		kv[0] = '0;
		kv[1] = 17'(axis_in.az);
		kv[2] = -17'(axis_in.ay);
		kv[3] = -17'(axis_in.az);
		kv[4] = '0;
		kv[5] = 17'(axis_in.ax);
		kv[6] = 17'(axis_in.ay);
		kv[7] = -17'(axis_in.ax);
		kv[8] = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				kkv[r*3+c] = 34'(kv[r*3] * kv[c]) + 34'(kv[r*3+1] * kv[3+c])
					+ 34'(kv[r*3+2] * kv[6+c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			s_s1 <= SW'(sr);
			omc_s1 <= SW'(One - cr);
			kk_s1 <= kkv;
			k_s1 <= kv;
		end
	end

	// stage 2: products with rounding
	logic signed [33:0] sk_s2 [9];
	logic signed [33:0] ok_s2 [9];
	logic signed [OpW-1:0] op [9];
	logic signed [SpW-1:0] sp [9];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			sp[i] = SpW'(s_s1) * SpW'(k_s1[i]);
			op[i] = OpW'(omc_s1) * OpW'(kk_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 9; i++) begin
				sk_s2[i] <= 34'((sp[i] + SpRnd) >>> FRAC_BITS);
				ok_s2[i] <= 34'((op[i] + OpRnd) >>> (2*FRAC_BITS));
			end
		end
	end

	// stage 3: sum and saturate
	logic signed [15:0] rv [9];
	logic signed [35:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = 36'(sk_s2[i]) + 36'(ok_s2[i]) + ((i % 4 == 0) ? 36'(One) : 36'sd0);
			if (sum > 36'sd32767) rv[i] = 16'sh7fff;
			else if (sum < -36'sd32768) rv[i] = 16'sh8000;
			else rv[i] = 16'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			mat_s3 <= {rv[0], rv[1], rv[2], rv[3], rv[4], rv[5], rv[6], rv[7], rv[8]};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix_core.sv =====
// top level: axis-angle to rotation matrix, cordic cell chain and matrix stages
// usage:
//   in channel carries axis_x, axis_y, axis_z (Q1.14) and angle (Q3.13)
//   out channel carries r00..r22 (Q1.14, saturated), one item per input item
//   the pipeline is an entry stage that reflects the angle, a register in
//   each cordic cell, three matrix stages and the output register; it
//   accepts one item per cycle while the output is not stalled
//   the whole chain moves as one pipeline; it advances whenever the output
//   register is empty or being taken, so a stalled receiver holds every
//   stage and drops ready on the input
//   reset clears all valid bits; no item is in flight after reset
//   the cordic cell chain performs one micro-rotation per cell
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_rotation_matrix_core
	import aarm_pkg::*;
#(
	parameter int CORDIC_STEPS = 14,
	parameter int FRAC_BITS = 14
) (
	input wire clk,
	input wire arst_n,
	aarm_stream_if.sink in_ch,
	aarm_stream_if.source out_ch
);
	localparam int Depth = CORDIC_STEPS + 5;

	logic [Depth-1:0] vld_q;
	logic adv;

	assign adv = !vld_q[Depth-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_ch.valid};
		end
	end

	// entry stage: widen and reflect angle
	cordic_state_t st_q [CORDIC_STEPS+1];
	axis_t axis_q [CORDIC_STEPS+1];
	cordic_word_t z0;
	cordic_state_t st0;

	always_comb begin
		z0 = 34'(signed'(in_ch.data[15:0])) <<< 16;
		st0.x = CordicGainQ30;
		st0.y = '0;
		st0.flip = 1'b0;
		st0.z = z0;
		if (z0 > HalfPiQ29) begin
			st0.z = PiQ29 - z0;
			st0.flip = 1'b1;
		end else if (z0 < -HalfPiQ29) begin
			st0.z = -PiQ29 - z0;
			st0.flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= st0;
			axis_q[0] <= {in_ch.data[63:48], in_ch.data[47:32], in_ch.data[31:16]};
		end
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		aarm_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk),
			.en(adv),
			.st_in(st_q[g]),
			.axis_in(axis_q[g]),
			.st_s1(st_q[g+1]),
			.axis_s1(axis_q[g+1])
		);
	end

	matrix_t mat;

	aarm_matrix_stage #(.FRAC_BITS(FRAC_BITS)) u_mat (
		.clk(clk),
		.en1(adv),
		.en2(adv),
		.en3(adv),
		.st_in(st_q[CORDIC_STEPS]),
		.axis_in(axis_q[CORDIC_STEPS]),
		.mat_s3(mat)
	);

	logic [143:0] out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= mat;
		end
	end

	assign out_ch.valid = vld_q[Depth-1];
	assign out_ch.data = out_q;
endmodule
`default_nettype wire
